/* rtl/jse_pkg.sv */
// Package for the JSON string escaper: item kinds, queue entry type,
// escape characters and the hex digit lookup. No dependencies.
`default_nettype none

package jse_pkg;

	localparam logic [15:0] CAP_RESET     = 16'd2048;
	localparam logic [16:0] ESC_MAX       = 17'd6;
	localparam logic [7:0]  CTRL_LIMIT    = 8'h20;
	localparam int          QUEUE_DEPTH_D = 4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LB     = 8'h62;
	localparam logic [7:0] CH_LF_ESC = 8'h66;
	localparam logic [7:0] CH_LN     = 8'h6E;
	localparam logic [7:0] CH_LR     = 8'h72;
	localparam logic [7:0] CH_LT     = 8'h74;
	localparam logic [7:0] CH_LU     = 8'h75;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_SHORT,
		KIND_UNICODE,
		KIND_TERM
	} esc_kind_t;

	typedef struct packed {
		esc_kind_t   kind;
		logic [7:0]  data;
		logic [15:0] length;
	} jse_entry_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'd0, nib};
		if (nib < 4'd10) begin
			return CH_ZERO + wide;
		end
		return CH_LA + wide - 8'd10;
	endfunction

	function automatic logic [2:0] esc_len(input esc_kind_t kind);
		case (kind)
			KIND_SHORT:   return 3'd2;
			KIND_UNICODE: return 3'd6;
			default:      return 3'd1;
		endcase
	endfunction

endpackage

`default_nettype wire

/* rtl/jse_front.sv */
// Front end of the JSON string escaper: accepts source bytes, applies the
// capacity check, keeps the running count and classifies each byte.
// Depends on jse_pkg.
`default_nettype none

module jse_front
	import jse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	input  wire logic        q_full,
	output logic             q_push,
	output jse_entry_t       q_entry
);

	logic [15:0] cap_q;
	logic [15:0] count_q;
	logic        accept;
	logic        room;
	logic [2:0]  n_bytes;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign room     = ({1'b0, count_q} + ESC_MAX) < {1'b0, cap_q};

	always_comb begin
		q_entry.kind   = KIND_PLAIN;
		q_entry.data   = in_byte;
		q_entry.length = 16'd0;
		if (in_byte == CH_NUL) begin
			q_entry.kind   = KIND_TERM;
			q_entry.length = count_q;
		end else begin
			case (in_byte)
				CH_QUOTE, CH_BSLASH: q_entry.kind = KIND_SHORT;
				CH_BS: begin
					q_entry.kind = KIND_SHORT;
					q_entry.data = CH_LB;
				end
				CH_FF: begin
					q_entry.kind = KIND_SHORT;
					q_entry.data = CH_LF_ESC;
				end
				CH_LF: begin
					q_entry.kind = KIND_SHORT;
					q_entry.data = CH_LN;
				end
				CH_CR: begin
					q_entry.kind = KIND_SHORT;
					q_entry.data = CH_LR;
				end
				CH_TAB: begin
					q_entry.kind = KIND_SHORT;
					q_entry.data = CH_LT;
				end
				default: begin
					if (in_byte < CTRL_LIMIT) begin
						q_entry.kind = KIND_UNICODE;
					end
				end
			endcase
		end
	end

	assign n_bytes = esc_len(q_entry.kind);
	assign q_push  = accept && ((in_byte == CH_NUL) || room);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= 16'd0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (accept) begin
				if (in_byte == CH_NUL) begin
					count_q <= 16'd0;
				end else if (room) begin
					count_q <= count_q + {13'd0, n_bytes};
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/jse_queue.sv */
// Short queue of classified items between the front and back ends of the
// JSON string escaper. Depends on jse_pkg.
`default_nettype none

module jse_queue
	import jse_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_D
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire jse_entry_t push_entry,
	output logic            full,
	input  wire logic       pop,
	output logic            head_valid,
	output jse_entry_t      head_entry
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	jse_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign full       = (cnt_q == FULL_CNT);
	assign head_valid = (cnt_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/jse_back.sv */
// Back end of the JSON string escaper: expands each queued item into its
// escape sequence, one byte per cycle while the output does not stall,
// into the output register. Depends on jse_pkg.
`default_nettype none

module jse_back
	import jse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  wire jse_entry_t  head_entry,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output logic             out_done,
	output logic [15:0]      out_length
);

	logic [2:0]  step_q;
	logic        load;
	logic        last;
	logic [7:0]  next_byte;

	assign load = head_valid && (!out_valid || out_ready);
	assign last = (step_q == esc_len(head_entry.kind) - 3'd1);
	assign pop  = load && last;

	always_comb begin
		case (head_entry.kind)
			KIND_SHORT: next_byte = (step_q == 3'd0) ? CH_BSLASH : head_entry.data;
			KIND_UNICODE: begin
				case (step_q)
					3'd0:    next_byte = CH_BSLASH;
					3'd1:    next_byte = CH_LU;
					3'd2:    next_byte = CH_ZERO;
					3'd3:    next_byte = CH_ZERO;
					3'd4:    next_byte = hex_digit(head_entry.data[7:4]);
					default: next_byte = hex_digit(head_entry.data[3:0]);
				endcase
			end
			KIND_TERM: next_byte = CH_NUL;
			default:   next_byte = head_entry.data;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte   <= next_byte;
			out_last   <= last;
			out_done   <= (head_entry.kind == KIND_TERM);
			out_length <= (head_entry.kind == KIND_TERM) ? head_entry.length : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			step_q    <= 3'd0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				step_q    <= last ? 3'd0 : step_q + 3'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/json_string_escaper.sv */
// JSON string escaper, top level. When the queue is empty, the first output
// byte of an item passes through the queue and then the output register. The output carries
// one byte per cycle while the receiver does not stall, set by the single byte lane of the
// back end; a byte yields 1, 2 or 6 output bytes by its escape, a dropped byte yields none.
// Reset (arst_n low) clears the count, the queue and the output, and sets
// the capacity to 2048. Depends on jse_pkg, jse_front, jse_queue, jse_back.
`default_nettype none

module json_string_escaper
	import jse_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] src_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // [7:0] out_byte, [23:8] total_length
	output logic             m_axis_tlast,  // run_last
	output logic             m_axis_tuser   // string_done
);

	logic       q_full;
	logic       q_push;
	logic       q_pop;
	logic       head_valid;
	jse_entry_t push_entry;
	jse_entry_t head_entry;

	jse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (push_entry)
	);

	jse_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	jse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata[7:0]),
		.out_last   (m_axis_tlast),
		.out_done   (m_axis_tuser),
		.out_length (m_axis_tdata[23:8])
	);

	// A terminator transfer is always the last byte of its item.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("terminator transfer without tlast");

	// Only the terminator carries a length.
	a_length_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:8] == 16'd0)
		else $error("length on a non-terminator transfer");

	// The front end never writes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("queue overflow");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for json_string_escaper: predicts the escaped byte stream per source
// byte and checks every output transfer. Depends only on the RTL top level.
`timescale 1ns / 1ps

module testbench;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_BS      = 8'h08;
	localparam logic [7:0] CH_FF      = 8'h0C;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [16:0] ESC_WORST = 17'd6;
	localparam logic [15:0] CAP_AT_RESET = 16'd2048;
	localparam logic [15:0] CAP_MAX   = 16'd65535;
	localparam logic [15:0] CAP_MIN   = 16'd7;
	localparam int DRAIN_LIMIT = 20000;
	localparam int HOLD_AT     = 120;
	localparam int HOLD_CYCLES = 300;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic [7:0]  ch;
		logic        last;
		logic        done;
		logic [15:0] len;
	} escaped_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;

	logic [7:0]    pending_bytes[$];
	escaped_byte_t expected_bytes[$];
	logic [15:0]   out_capacity = CAP_AT_RESET;
	logic [15:0]   written_count = '0;
	int            error_count = 0;

	json_string_escaper uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT) begin
			$display("ERROR at %0t ns: %s", $time, msg);
		end
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return 8'("0") + {4'd0, nib};
		end
		return 8'("a") + {4'd0, nib} - 8'd10;
	endfunction

	function automatic void predict_escape(input logic [7:0] ch);
		logic [7:0] seq [6];
		int n;
		escaped_byte_t r;
		n = 0;
		if (ch == CH_NUL) begin
			r = '{ch: CH_NUL, last: 1'b1, done: 1'b1, len: written_count};
			expected_bytes.push_back(r);
			written_count = '0;
			return;
		end
		if (!({1'b0, written_count} + ESC_WORST < {1'b0, out_capacity})) begin
			return;
		end
		seq[0] = "\\";
		n = 2;
		case (ch)
			CH_QUOTE:  seq[1] = "\"";
			CH_BSLASH: seq[1] = "\\";
			CH_BS:     seq[1] = "b";
			CH_FF:     seq[1] = "f";
			CH_LF:     seq[1] = "n";
			CH_CR:     seq[1] = "r";
			CH_TAB:    seq[1] = "t";
			default: begin
				if (ch < CTRL_LIMIT) begin
					seq[1] = "u";
					seq[2] = "0";
					seq[3] = "0";
					seq[4] = hex_char(ch[7:4]);
					seq[5] = hex_char(ch[3:0]);
					n = 6;
				end else begin
					seq[0] = ch;
					n = 1;
				end
			end
		endcase
		for (int i = 0; i < n; i++) begin
			r = '{ch: seq[i], last: (i == n - 1), done: 1'b0, len: 16'd0};
			expected_bytes.push_back(r);
		end
		written_count = written_count + 16'(n);
	endfunction

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk) begin : sender
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_escape(s_axis_tdata);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					s_axis_tdata <= pending_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: changing stall pattern, plus one long hold-off once enough has come out.
	always @(posedge clk) begin : receiver
		int delivered;
		int hold_left;
		int mode_left;
		int mode;
		bit hold_done;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			delivered = 0;
			hold_left = 0;
			mode_left = 0;
			mode = 0;
			hold_done = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				delivered++;
			end
			if (mode_left <= 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 64);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && delivered >= HOLD_AT && pending_bytes.size() > 8) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ~m_axis_tready;
				endcase
			end
		end
	end

	always @(posedge clk) begin : monitor
		escaped_byte_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_bytes.size() == 0) begin
				report_error($sformatf("unexpected output byte %02h", m_axis_tdata[7:0]));
			end else begin
				want = expected_bytes.pop_front();
				if (m_axis_tdata[7:0] !== want.ch) begin
					report_error($sformatf("out_byte %02h, expected %02h",
						m_axis_tdata[7:0], want.ch));
				end
				if (m_axis_tlast !== want.last) begin
					report_error($sformatf("run_last %b, expected %b", m_axis_tlast, want.last));
				end
				if (m_axis_tuser !== want.done) begin
					report_error($sformatf("string_done %b, expected %b",
						m_axis_tuser, want.done));
				end
				if (m_axis_tdata[23:8] !== want.len) begin
					report_error($sformatf("total_length %0d, expected %0d",
						m_axis_tdata[23:8], want.len));
				end
			end
		end
	end

	task automatic wait_drained();
		int guard;
		guard = 0;
		while ((pending_bytes.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0)
				&& guard < DRAIN_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		if (guard >= DRAIN_LIMIT) begin
			report_error($sformatf("%0d expected output bytes never arrived",
				expected_bytes.size()));
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [15:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		out_capacity = value;
	endtask

	function automatic logic [7:0] random_src_byte();
		logic [7:0] specials [7];
		specials = '{CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 8'($urandom_range(8'h20, 8'h7E));
			5, 6:          return specials[$urandom_range(0, 6)];
			7:             return 8'($urandom_range(1, 8'h1F));
			8:             return 8'($urandom_range(8'h80, 8'hFF));
			default:       return 8'($urandom_range(1, 8'hFF));
		endcase
	endfunction

	// Mostly whole strings with random content; some lack the terminator and run on.
	task automatic queue_strings(input int n_items);
		int added;
		int len;
		added = 0;
		while (added < n_items) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 12);
			for (int i = 0; i < len; i++) begin
				pending_bytes.push_back(random_src_byte());
			end
			added += len;
			if ($urandom_range(0, 7) != 0) begin
				pending_bytes.push_back(CH_NUL);
				added++;
			end
		end
	endtask

	initial begin
		logic [7:0] directed [$];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset capacity: every escape class, the control and byte extremes, an empty string.
		directed = '{CH_NUL, CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB,
			8'h01, 8'h1F, 8'h10, CTRL_LIMIT, 8'h7F, 8'h80, 8'hFF, 8'h41, CH_NUL};
		pending_bytes = directed;
		wait_drained();

		// Smallest capacity: one six-byte escape just fits, then the next byte is dropped.
		set_capacity(CAP_MIN);
		pending_bytes = '{8'h01, 8'h41, CH_NUL};
		wait_drained();

		// Capacity below its range drops everything but the terminator.
		set_capacity(16'd0);
		pending_bytes = '{8'h41, CH_NUL};
		wait_drained();

		// Capacity lowered in the middle of a string keeps the count reached so far.
		set_capacity(16'd9);
		pending_bytes = '{8'h41, 8'h42};
		wait_drained();
		set_capacity(CAP_MIN);
		pending_bytes = '{8'h43, CH_NUL};
		wait_drained();

		set_capacity(CAP_MAX);
		queue_strings(30);
		wait_drained();
		set_capacity(16'($urandom_range(7, 40)));
		queue_strings(30);
		wait_drained();
		set_capacity(16'($urandom_range(41, 300)));
		queue_strings(30);
		wait_drained();
		set_capacity(16'($urandom_range(0, 6)));
		queue_strings(20);
		wait_drained();
		set_capacity(CAP_AT_RESET);
		queue_strings(30);
		wait_drained();
		set_capacity(16'($urandom_range(7, 16)));
		queue_strings(30);
		pending_bytes.push_back(CH_NUL);
		wait_drained();

		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
rtl/jse_pkg.sv
rtl/jse_front.sv
rtl/jse_queue.sv
rtl/jse_back.sv
rtl/json_string_escaper.sv
tb/testbench.sv
